// ----- rtl/mvna_pkg.sv -----
package mvna_pkg;

    localparam int VERTEX_COUNT = 65536;
    localparam int SUM_WIDTH    = 24;
    localparam int ADDR_W       = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
    localparam int INDEX_W      = 16;
    localparam int POS_W        = 24;
    localparam int NORM_W       = 16;
    localparam int MUL_W        = 32;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int VEC_W        = 52;
    localparam int MAG_W        = VEC_W - 1;
    localparam int TOP_BIT      = 29;
    localparam int SQ_W         = 64;
    localparam int SQRT_STEPS   = 32;
    localparam int LEN_W        = 31;
    localparam int Q_W          = 15;
    localparam int FRAC_SH      = 15;
    localparam int DIV_W        = LEN_W + 1 + Q_W;
    localparam int STEP_W       = 6;
    localparam int Q_ONE        = 16384;

    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_TRI  = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;

    typedef logic [ADDR_W-1:0]             addr_t;
    typedef logic [INDEX_W-1:0]            index_t;
    typedef logic signed [POS_W-1:0]       pos_t;
    typedef logic signed [POS_W:0]         dif_t;
    typedef logic signed [MUL_W-1:0]       mul_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [VEC_W-1:0]       vec_t;
    typedef logic [MAG_W-1:0]              mag_t;
    typedef logic [SQ_W-1:0]               sq_t;
    typedef logic [DIV_W-1:0]              div_t;
    typedef logic [Q_W-1:0]                q_t;
    typedef logic signed [NORM_W-1:0]      nrm_t;
    typedef logic signed [SUM_WIDTH-1:0]   sum_t;
    typedef logic signed [SUM_WIDTH:0]     sumx_t;

    localparam sumx_t SUM_MAX = {2'b00, {(SUM_WIDTH-1){1'b1}}};
    localparam sumx_t SUM_MIN = {2'b11, {(SUM_WIDTH-1){1'b0}}};

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LD_WR,
        ST_T_RDA,
        ST_T_RDB,
        ST_T_RDC,
        ST_T_RDW,
        ST_CROSS,
        ST_R_RD,
        ST_R_CAP,
        ST_N_START,
        ST_N_SHIFT,
        ST_N_SQ,
        ST_N_SQRT,
        ST_N_DIVINIT,
        ST_N_DIV,
        ST_N_OUT,
        ST_DOT,
        ST_SUM_RD,
        ST_SUM_WR,
        ST_R_OUT
    } state_t;

endpackage

// ----- rtl/mvna_ram.sv -----
module mvna_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/mesh_vertex_normal_accumulator_top.sv -----
// Vertex normal accumulator: load positions, add triangle normals, read unit normals.
// A read result waits while the previous output word has not been taken.
// Time is set by the shared 32x32 multiplier, the one-bit-a-cycle shift normalizer,
// the 32-step square root and the 15-step three-lane divider. One item at a time.
// Reset (aresetn low, synchronous) clears control and starts a clearing pass over
// all VERTEX_COUNT entries of the sum memory; s_tready stays low until it ends.
module mesh_vertex_normal_accumulator_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // index_a[15:0], index_b[31:16], index_c[47:32], pos_x[71:48], pos_y[95:72], pos_z[119:96]
    input  logic [119:0] s_tdata,
    // func[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // normal_x[15:0], normal_y[31:16], normal_z[47:32]
    output logic [47:0]  m_tdata,
    // zero_normal[0]
    output logic [0:0]   m_tuser
);

    localparam int SW = mvna_pkg::SUM_WIDTH;
    localparam int PW = mvna_pkg::POS_W;

    mvna_pkg::state_t state_reg, state_next;
    mvna_pkg::addr_t  clr_cnt_reg, clr_cnt_next;

    logic [1:0]        func_reg, func_next;
    mvna_pkg::index_t  idx_reg [3];
    mvna_pkg::index_t  idx_next [3];
    logic [3*PW-1:0]   pos_reg, pos_next;
    logic              ia_ok_reg, ia_ok_next;

    mvna_pkg::pos_t    apos_reg [3];
    mvna_pkg::pos_t    apos_next [3];
    mvna_pkg::dif_t    u_reg [3];
    mvna_pkg::dif_t    u_next [3];
    mvna_pkg::dif_t    w_reg [3];
    mvna_pkg::dif_t    w_next [3];
    mvna_pkg::vec_t    vec_reg [3];
    mvna_pkg::vec_t    vec_next [3];
    logic              neg_reg [3];
    logic              neg_next [3];
    mvna_pkg::mag_t    mag_reg [3];
    mvna_pkg::mag_t    mag_next [3];
    mvna_pkg::mag_t    mmax_reg, mmax_next;
    logic [mvna_pkg::STEP_W-1:0] step_reg, step_next;
    mvna_pkg::prod_t   prod_reg, acc_reg, acc_next;
    mvna_pkg::sq_t     sqn_reg, sqn_next, root_reg, root_next;
    mvna_pkg::div_t    dsh_reg, dsh_next;
    mvna_pkg::div_t    rem_reg [3];
    mvna_pkg::div_t    rem_next [3];
    mvna_pkg::q_t      q_reg [3];
    mvna_pkg::q_t      q_next [3];
    mvna_pkg::nrm_t    nrm_reg [3];
    mvna_pkg::nrm_t    nrm_next [3];
    logic              zero_reg, zero_next;
    logic [1:0]        corner_reg, corner_next;

    logic              m_valid_reg, m_valid_next;
    logic [47:0]       m_data_reg, m_data_next;
    logic              m_user_reg, m_user_next;

    // memory ports
    logic              vert_we;
    mvna_pkg::addr_t   vert_waddr, vert_raddr;
    logic [3*PW-1:0]   vert_rdata;
    logic              sum_we;
    mvna_pkg::addr_t   sum_waddr, sum_raddr;
    logic [3*SW-1:0]   sum_wdata, sum_rdata;

    // shared multiplier and helpers
    mvna_pkg::mul_t    mul_a, mul_b;
    mvna_pkg::prod_t   acc_sum;
    mvna_pkg::vec_t    absv [3];
    mvna_pkg::mag_t    amag [3];
    mvna_pkg::mag_t    amax;
    mvna_pkg::sq_t     sq_bit, root_plus;
    logic [2:0]        xk;
    logic [1:0]        xj;
    mvna_pkg::q_t      qc;
    mvna_pkg::sumx_t   sat_t [3];
    mvna_pkg::state_t  done_state;
    logic              in_ok [3];
    logic              accept;

    assign accept  = s_tvalid && s_tready;
    assign s_tready = (state_reg == mvna_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    assign acc_sum = acc_reg + prod_reg;
    assign sq_bit  = mvna_pkg::sq_t'(1) << {step_reg[4:0], 1'b0};
    assign root_plus = root_reg + sq_bit;
    assign xk = step_reg[2:0] - 3'd1;
    assign xj = xk[2:1];
    assign done_state = (func_reg == mvna_pkg::FUNC_TRI) ? mvna_pkg::ST_DOT
                                                          : mvna_pkg::ST_R_OUT;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_ok[i] = {1'b0, s_tdata[16*i +: 16]} < 17'(mvna_pkg::VERTEX_COUNT);
            absv[i]  = vec_reg[i][mvna_pkg::VEC_W-1] ? -vec_reg[i] : vec_reg[i];
            amag[i]  = absv[i][mvna_pkg::MAG_W-1:0];
            sat_t[i] = mvna_pkg::sumx_t'($signed(sum_rdata[i*SW +: SW]))
                     + mvna_pkg::sumx_t'(nrm_reg[i]);
        end
        amax = amag[0];
        if (amag[1] > amax) begin
            amax = amag[1];
        end
        if (amag[2] > amax) begin
            amax = amag[2];
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            mvna_pkg::ST_CROSS: begin
                case (step_reg[2:0])
                    3'd0: begin mul_a = mvna_pkg::mul_t'(u_reg[1]); mul_b = mvna_pkg::mul_t'(w_reg[2]); end
                    3'd1: begin mul_a = mvna_pkg::mul_t'(u_reg[2]); mul_b = mvna_pkg::mul_t'(w_reg[1]); end
                    3'd2: begin mul_a = mvna_pkg::mul_t'(u_reg[2]); mul_b = mvna_pkg::mul_t'(w_reg[0]); end
                    3'd3: begin mul_a = mvna_pkg::mul_t'(u_reg[0]); mul_b = mvna_pkg::mul_t'(w_reg[2]); end
                    3'd4: begin mul_a = mvna_pkg::mul_t'(u_reg[0]); mul_b = mvna_pkg::mul_t'(w_reg[1]); end
                    3'd5: begin mul_a = mvna_pkg::mul_t'(u_reg[1]); mul_b = mvna_pkg::mul_t'(w_reg[0]); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            mvna_pkg::ST_N_SQ: begin
                if (step_reg < 6'd3) begin
                    mul_a = $signed({2'b00, mag_reg[step_reg[1:0]][mvna_pkg::TOP_BIT:0]});
                    mul_b = mul_a;
                end
            end
            mvna_pkg::ST_DOT: begin
                if (step_reg < 6'd3) begin
                    mul_a = mvna_pkg::mul_t'(apos_reg[step_reg[1:0]]);
                    mul_b = mvna_pkg::mul_t'(nrm_reg[step_reg[1:0]]);
                end
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        func_next    = func_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        ia_ok_next   = ia_ok_reg;
        apos_next    = apos_reg;
        u_next       = u_reg;
        w_next       = w_reg;
        vec_next     = vec_reg;
        neg_next     = neg_reg;
        mag_next     = mag_reg;
        mmax_next    = mmax_reg;
        step_next    = step_reg;
        acc_next     = acc_reg;
        sqn_next     = sqn_reg;
        root_next    = root_reg;
        dsh_next     = dsh_reg;
        rem_next     = rem_reg;
        q_next       = q_reg;
        nrm_next     = nrm_reg;
        zero_next    = zero_reg;
        corner_next  = corner_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        vert_we      = 1'b0;
        vert_waddr   = idx_reg[0][mvna_pkg::ADDR_W-1:0];
        vert_raddr   = idx_reg[0][mvna_pkg::ADDR_W-1:0];
        sum_we       = 1'b0;
        sum_waddr    = idx_reg[corner_reg][mvna_pkg::ADDR_W-1:0];
        sum_raddr    = idx_reg[corner_reg][mvna_pkg::ADDR_W-1:0];
        sum_wdata    = '0;
        qc           = '0;

        // drop the result word once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            mvna_pkg::ST_CLEAR: begin
                sum_we    = 1'b1;
                sum_waddr = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == mvna_pkg::addr_t'(mvna_pkg::VERTEX_COUNT - 1)) begin
                    state_next = mvna_pkg::ST_IDLE;
                end
            end
            mvna_pkg::ST_IDLE: begin
                if (accept) begin
                    func_next  = s_tuser;
                    for (int i = 0; i < 3; i++) begin
                        idx_next[i] = s_tdata[16*i +: 16];
                    end
                    pos_next   = s_tdata[48 +: 3*PW];
                    ia_ok_next = in_ok[0];
                    corner_next = 2'd0;
                    case (s_tuser)
                        mvna_pkg::FUNC_LOAD: begin
                            state_next = in_ok[0] ? mvna_pkg::ST_LD_WR : mvna_pkg::ST_IDLE;
                        end
                        mvna_pkg::FUNC_TRI: begin
                            state_next = (in_ok[0] && in_ok[1] && in_ok[2])
                                       ? mvna_pkg::ST_T_RDA : mvna_pkg::ST_IDLE;
                        end
                        mvna_pkg::FUNC_READ: begin
                            state_next = mvna_pkg::ST_R_RD;
                        end
                        default: begin
                            state_next = mvna_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            mvna_pkg::ST_LD_WR: begin
                vert_we    = 1'b1;
                state_next = mvna_pkg::ST_IDLE;
            end
            mvna_pkg::ST_T_RDA: begin
                vert_raddr = idx_reg[0][mvna_pkg::ADDR_W-1:0];
                state_next = mvna_pkg::ST_T_RDB;
            end
            mvna_pkg::ST_T_RDB: begin
                vert_raddr = idx_reg[1][mvna_pkg::ADDR_W-1:0];
                for (int i = 0; i < 3; i++) begin
                    apos_next[i] = vert_rdata[i*PW +: PW];
                end
                state_next = mvna_pkg::ST_T_RDC;
            end
            mvna_pkg::ST_T_RDC: begin
                vert_raddr = idx_reg[2][mvna_pkg::ADDR_W-1:0];
                for (int i = 0; i < 3; i++) begin
                    u_next[i] = mvna_pkg::dif_t'($signed(vert_rdata[i*PW +: PW]))
                              - mvna_pkg::dif_t'(apos_reg[i]);
                end
                state_next = mvna_pkg::ST_T_RDW;
            end
            mvna_pkg::ST_T_RDW: begin
                for (int i = 0; i < 3; i++) begin
                    w_next[i] = mvna_pkg::dif_t'($signed(vert_rdata[i*PW +: PW]))
                              - mvna_pkg::dif_t'(apos_reg[i]);
                end
                step_next  = '0;
                state_next = mvna_pkg::ST_CROSS;
            end
            mvna_pkg::ST_CROSS: begin
                // even product opens a component, odd product is subtracted
                if (step_reg != '0) begin
                    if (!xk[0]) begin
                        vec_next[xj] = mvna_pkg::vec_t'(prod_reg);
                    end else begin
                        vec_next[xj] = vec_reg[xj] - mvna_pkg::vec_t'(prod_reg);
                    end
                end
                step_next = step_reg + 1'b1;
                if (step_reg == 6'd6) begin
                    state_next = mvna_pkg::ST_N_START;
                end
            end
            mvna_pkg::ST_R_RD: begin
                sum_raddr  = idx_reg[0][mvna_pkg::ADDR_W-1:0];
                state_next = mvna_pkg::ST_R_CAP;
            end
            mvna_pkg::ST_R_CAP: begin
                for (int i = 0; i < 3; i++) begin
                    vec_next[i] = ia_ok_reg
                                ? mvna_pkg::vec_t'($signed(sum_rdata[i*SW +: SW])) : '0;
                end
                state_next = mvna_pkg::ST_N_START;
            end
            mvna_pkg::ST_N_START: begin
                for (int i = 0; i < 3; i++) begin
                    neg_next[i] = vec_reg[i][mvna_pkg::VEC_W-1];
                    mag_next[i] = amag[i];
                end
                mmax_next = amax;
                if (amax == '0) begin
                    for (int i = 0; i < 3; i++) begin
                        nrm_next[i] = '0;
                    end
                    zero_next  = 1'b1;
                    step_next  = '0;
                    state_next = done_state;
                end else begin
                    state_next = mvna_pkg::ST_N_SHIFT;
                end
            end
            mvna_pkg::ST_N_SHIFT: begin
                // walk the largest magnitude until its top bit sits at TOP_BIT
                if (mmax_reg[mvna_pkg::MAG_W-1:mvna_pkg::TOP_BIT+1] != '0) begin
                    mmax_next = mmax_reg >> 1;
                    for (int i = 0; i < 3; i++) begin
                        mag_next[i] = mag_reg[i] >> 1;
                    end
                end else if (!mmax_reg[mvna_pkg::TOP_BIT]) begin
                    mmax_next = mmax_reg << 1;
                    for (int i = 0; i < 3; i++) begin
                        mag_next[i] = mag_reg[i] << 1;
                    end
                end else begin
                    step_next  = '0;
                    state_next = mvna_pkg::ST_N_SQ;
                end
            end
            mvna_pkg::ST_N_SQ: begin
                step_next = step_reg + 1'b1;
                if (step_reg == 6'd1) begin
                    acc_next = prod_reg;
                end else if (step_reg == 6'd2) begin
                    acc_next = acc_sum;
                end else if (step_reg == 6'd3) begin
                    sqn_next   = mvna_pkg::sq_t'(acc_sum);
                    root_next  = '0;
                    step_next  = mvna_pkg::STEP_W'(mvna_pkg::SQRT_STEPS - 1);
                    state_next = mvna_pkg::ST_N_SQRT;
                end
            end
            mvna_pkg::ST_N_SQRT: begin
                if (sqn_reg >= root_plus) begin
                    sqn_next  = sqn_reg - root_plus;
                    root_next = (root_reg >> 1) + sq_bit;
                end else begin
                    root_next = root_reg >> 1;
                end
                step_next = step_reg - 1'b1;
                if (step_reg == '0) begin
                    state_next = mvna_pkg::ST_N_DIVINIT;
                end
            end
            mvna_pkg::ST_N_DIVINIT: begin
                dsh_next = mvna_pkg::div_t'({root_reg[mvna_pkg::LEN_W-1:0], 1'b0})
                           << (mvna_pkg::Q_W - 1);
                for (int i = 0; i < 3; i++) begin
                    rem_next[i] = mvna_pkg::div_t'({mag_reg[i][mvna_pkg::TOP_BIT:0],
                                                    {mvna_pkg::FRAC_SH{1'b0}}})
                                + mvna_pkg::div_t'(root_reg[mvna_pkg::LEN_W-1:0]);
                    q_next[i] = '0;
                end
                step_next  = mvna_pkg::STEP_W'(mvna_pkg::Q_W - 1);
                state_next = mvna_pkg::ST_N_DIV;
            end
            mvna_pkg::ST_N_DIV: begin
                for (int i = 0; i < 3; i++) begin
                    if (rem_reg[i] >= dsh_reg) begin
                        rem_next[i] = rem_reg[i] - dsh_reg;
                        q_next[i]   = {q_reg[i][mvna_pkg::Q_W-2:0], 1'b1};
                    end else begin
                        q_next[i]   = {q_reg[i][mvna_pkg::Q_W-2:0], 1'b0};
                    end
                end
                dsh_next  = dsh_reg >> 1;
                step_next = step_reg - 1'b1;
                if (step_reg == '0) begin
                    state_next = mvna_pkg::ST_N_OUT;
                end
            end
            mvna_pkg::ST_N_OUT: begin
                for (int i = 0; i < 3; i++) begin
                    qc = (q_reg[i] > mvna_pkg::q_t'(mvna_pkg::Q_ONE))
                       ? mvna_pkg::q_t'(mvna_pkg::Q_ONE) : q_reg[i];
                    nrm_next[i] = neg_reg[i] ? -mvna_pkg::nrm_t'({1'b0, qc})
                                             :  mvna_pkg::nrm_t'({1'b0, qc});
                end
                zero_next  = 1'b0;
                step_next  = '0;
                state_next = done_state;
            end
            mvna_pkg::ST_DOT: begin
                step_next = step_reg + 1'b1;
                if (step_reg == 6'd1) begin
                    acc_next = prod_reg;
                end else if (step_reg == 6'd2) begin
                    acc_next = acc_sum;
                end else if (step_reg == 6'd3) begin
                    // flip a normal that points along A
                    if (acc_sum > 0) begin
                        for (int i = 0; i < 3; i++) begin
                            nrm_next[i] = -nrm_reg[i];
                        end
                    end
                    corner_next = 2'd0;
                    state_next  = mvna_pkg::ST_SUM_RD;
                end
            end
            mvna_pkg::ST_SUM_RD: begin
                state_next = mvna_pkg::ST_SUM_WR;
            end
            mvna_pkg::ST_SUM_WR: begin
                sum_we = 1'b1;
                for (int i = 0; i < 3; i++) begin
                    if (sat_t[i] > mvna_pkg::SUM_MAX) begin
                        sum_wdata[i*SW +: SW] = mvna_pkg::SUM_MAX[SW-1:0];
                    end else if (sat_t[i] < mvna_pkg::SUM_MIN) begin
                        sum_wdata[i*SW +: SW] = mvna_pkg::SUM_MIN[SW-1:0];
                    end else begin
                        sum_wdata[i*SW +: SW] = sat_t[i][SW-1:0];
                    end
                end
                corner_next = corner_reg + 1'b1;
                state_next  = (corner_reg == 2'd2) ? mvna_pkg::ST_IDLE : mvna_pkg::ST_SUM_RD;
            end
            mvna_pkg::ST_R_OUT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {nrm_reg[2], nrm_reg[1], nrm_reg[0]};
                    m_user_next  = zero_reg;
                    state_next   = mvna_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mvna_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mvna_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg   <= func_next;
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        ia_ok_reg  <= ia_ok_next;
        apos_reg   <= apos_next;
        u_reg      <= u_next;
        w_reg      <= w_next;
        vec_reg    <= vec_next;
        neg_reg    <= neg_next;
        mag_reg    <= mag_next;
        mmax_reg   <= mmax_next;
        step_reg   <= step_next;
        acc_reg    <= acc_next;
        sqn_reg    <= sqn_next;
        root_reg   <= root_next;
        dsh_reg    <= dsh_next;
        rem_reg    <= rem_next;
        q_reg      <= q_next;
        nrm_reg    <= nrm_next;
        zero_reg   <= zero_next;
        corner_reg <= corner_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    mvna_ram #(
        .WIDTH (3 * PW),
        .DEPTH (mvna_pkg::VERTEX_COUNT)
    ) u_vert_ram (
        .aclk  (aclk),
        .we    (vert_we),
        .waddr (vert_waddr),
        .wdata (pos_reg),
        .raddr (vert_raddr),
        .rdata (vert_rdata)
    );

    mvna_ram #(
        .WIDTH (3 * SW),
        .DEPTH (mvna_pkg::VERTEX_COUNT)
    ) u_sum_ram (
        .aclk  (aclk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    // no item enters during the clearing pass
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mvna_pkg::ST_CLEAR) |-> !s_tready)
        else $error("item accepted during sum clear");

    // a sum write follows its own read
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mvna_pkg::ST_SUM_WR) |-> ($past(state_reg) == mvna_pkg::ST_SUM_RD))
        else $error("sum write without read");

    // a zero flag carries zero components
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("zero flag with nonzero normal");

    // components stay within unit range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd16384
                  && $signed(m_tdata[15:0]) >= -16'sd16384
                  && $signed(m_tdata[31:16]) <= 16'sd16384
                  && $signed(m_tdata[31:16]) >= -16'sd16384
                  && $signed(m_tdata[47:32]) <= 16'sd16384
                  && $signed(m_tdata[47:32]) >= -16'sd16384))
        else $error("normal component out of range");

endmodule
